>>> design/elu_pkg.sv
// Shared types, constants and the exponential lookup tables for the ELU activation block.
`default_nettype none

package elu_pkg;

   // Fixed-point format and table geometry.
   localparam int FRAC_BITS     = 12;
   localparam int TABLE_ENTRIES = 64;
   localparam int SEG_BITS      = FRAC_BITS + 3;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int MAG_BITS      = 16;
   localparam int PROD_BITS     = MAG_BITS + IDX_BITS;
   localparam int SEG_IDX_BITS  = PROD_BITS - SEG_BITS;
   localparam int SERIES_TERMS  = 24;

   // The alpha register is unsigned with the same fraction bits; it resets to 1.0.
   localparam int ALPHA_BITS = 15;
   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(1 << FRAC_BITS);

   // Input word and result word.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] activation;
      logic               last_out;
   } rsp_word_type;

   // Control that travels with every sample down the pipeline.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic signed [15:0] sample;
   } tag_type;

   // Output of the index stage: table segment and position inside it.
   typedef struct packed {
      tag_type               tag;
      logic [IDX_BITS-1:0]   idx;
      logic [SEG_BITS-1:0]   frac;
   } index_stage_type;

   // Output of the interpolation stages: magnitude of exp(x)-1 in unsigned Q32.
   typedef struct packed {
      tag_type     tag;
      logic [31:0] q;
   } q_stage_type;

   typedef logic [32:0] exp_rom_type [TABLE_ENTRIES+1];
   typedef logic [31:0] diff_rom_type [TABLE_ENTRIES+1];

   // Builds exp(-8k/N) in Q32 for k = 0..N from a truncated series for one step ratio.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type        rom;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        ratio;
      logic [63:0]        prev;
      term = 64'd1 << 32;
      sum  = $signed(term);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = (term * 64'd8) / 64'(TABLE_ENTRIES * n);
         if ((n & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      ratio  = $unsigned(sum);
      prev   = 64'd1 << 32;
      rom[0] = prev[32:0];
      for (int k = 1; k <= TABLE_ENTRIES; k++) begin
         prev   = (prev * ratio) >> 32;
         rom[k] = prev[32:0];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

   // Drop from each table entry to the next; the entry past the end is zero.
   function automatic diff_rom_type build_diff_rom();
      diff_rom_type rom;
      logic [32:0]  delta;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         delta  = EXP_ROM[k] - EXP_ROM[k+1];
         rom[k] = delta[31:0];
      end
      rom[TABLE_ENTRIES] = '0;
      return rom;
   endfunction

   localparam diff_rom_type DIFF_ROM = build_diff_rom();

endpackage

`default_nettype wire

>>> design/elu_index.sv
// First pipeline stage: magnitude of a negative sample split into table index and fraction.
`default_nettype none

module elu_index (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire elu_pkg::req_word_type    in_word,
   output elu_pkg::index_stage_type      out_stage
);
   import elu_pkg::*;

   logic [MAG_BITS-1:0]     mag;
   logic [PROD_BITS-1:0]    pos;
   logic [SEG_IDX_BITS-1:0] seg;
   logic [IDX_BITS-1:0]     idx_in;
   logic [SEG_BITS-1:0]     frac_in;

   logic                    valid_ff;
   logic                    last_ff;
   logic signed [15:0]      sample_ff;
   logic [IDX_BITS-1:0]     idx_ff;
   logic [SEG_BITS-1:0]     frac_ff;

   // Position along the table: magnitude times the entry count, by a constant.
   always_comb begin
      mag = MAG_BITS'(~in_word.sample + 16'sd1);
      pos = PROD_BITS'(mag) * PROD_BITS'(TABLE_ENTRIES);
      seg = pos[PROD_BITS-1:SEG_BITS];
   end

   // Past the end of the table the last entry is used with no interpolation.
   always_comb begin
      if (32'(seg) >= 32'(TABLE_ENTRIES)) begin
         idx_in  = IDX_BITS'(TABLE_ENTRIES);
         frac_in = '0;
      end else begin
         idx_in  = IDX_BITS'(seg);
         frac_in = pos[SEG_BITS-1:0];
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      last_ff   <= in_word.last;
      sample_ff <= in_word.sample;
      idx_ff    <= idx_in;
      frac_ff   <= frac_in;
   end

   assign out_stage.tag.valid  = valid_ff;
   assign out_stage.tag.last   = last_ff;
   assign out_stage.tag.sample = sample_ff;
   assign out_stage.idx        = idx_ff;
   assign out_stage.frac       = frac_ff;

endmodule

`default_nettype wire

>>> design/elu_interp.sv
// Table read and linear interpolation of exp(x), giving the magnitude of exp(x)-1.
`default_nettype none

module elu_interp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire elu_pkg::index_stage_type   in_stage,
   output elu_pkg::q_stage_type            out_stage
);
   import elu_pkg::*;

   // Stage A: table read.
   tag_type               tag_a_ff;
   logic [32:0]           base_a_ff;
   logic [31:0]           diff_a_ff;
   logic [SEG_BITS-1:0]   frac_a_ff;

   // Stage B: slope times fraction.
   tag_type               tag_b_ff;
   logic [32:0]           base_b_ff;
   logic [31:0]           step_b_ff;
   logic [31+SEG_BITS:0]  step_full;

   // Stage C: interpolated value subtracted from one.
   tag_type               tag_c_ff;
   logic [31:0]           q_c_ff;
   logic [32:0]           e_val;
   logic [32:0]           q_full;

   always_comb begin
      step_full = (32+SEG_BITS)'(diff_a_ff) * (32+SEG_BITS)'(frac_a_ff);
      e_val     = base_b_ff - 33'(step_b_ff);
      q_full    = (33'd1 << 32) - e_val;
   end

   // Registers of the three stages; only the valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
         tag_c_ff.valid <= 1'b0;
      end else begin
         tag_a_ff.valid <= in_stage.tag.valid;
         tag_b_ff.valid <= tag_a_ff.valid;
         tag_c_ff.valid <= tag_b_ff.valid;
      end

      tag_a_ff.last   <= in_stage.tag.last;
      tag_a_ff.sample <= in_stage.tag.sample;
      base_a_ff       <= EXP_ROM[in_stage.idx];
      diff_a_ff       <= DIFF_ROM[in_stage.idx];
      frac_a_ff       <= in_stage.frac;

      tag_b_ff.last   <= tag_a_ff.last;
      tag_b_ff.sample <= tag_a_ff.sample;
      base_b_ff       <= base_a_ff;
      step_b_ff       <= step_full[31+SEG_BITS:SEG_BITS];

      tag_c_ff.last   <= tag_b_ff.last;
      tag_c_ff.sample <= tag_b_ff.sample;
      q_c_ff          <= q_full[31:0];
   end

   assign out_stage.tag = tag_c_ff;
   assign out_stage.q   = q_c_ff;

endmodule

`default_nettype wire

>>> design/elu_scale.sv
// Alpha scaling, rounding, saturation and selection of the result word.
`default_nettype none

module elu_scale (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire elu_pkg::q_stage_type           in_stage,
   input  wire logic [elu_pkg::ALPHA_BITS-1:0] alpha,
   output logic                                out_strobe,
   output elu_pkg::rsp_word_type               out_word
);
   import elu_pkg::*;

   localparam int SCALE_BITS = ALPHA_BITS + 32;
   localparam logic [15:0] NEG_LIMIT = 16'h8000;

   // Stage D: product of alpha and the magnitude.
   tag_type                 tag_d_ff;
   logic [SCALE_BITS-1:0]   scaled_d_ff;

   // Stage E: rounded, negated and saturated result.
   logic [SCALE_BITS:0]     rounded;
   logic [15:0]             mag_r;
   logic signed [15:0]      activation_in;
   logic                    strobe_ff;
   rsp_word_type            word_ff;

   // Round half up, keep the integer part, then negate with a guard at the bottom.
   always_comb begin
      rounded = (SCALE_BITS+1)'(scaled_d_ff) + ((SCALE_BITS+1)'(1) << 31);
      mag_r   = rounded[47:32];
      if (tag_d_ff.sample[15]) begin
         if (mag_r > NEG_LIMIT) begin
            activation_in = $signed(NEG_LIMIT);
         end else begin
            activation_in = $signed(16'(~mag_r + 16'd1));
         end
      end else begin
         activation_in = tag_d_ff.sample;
      end
   end

   // Stage registers; only the valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff.valid <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         tag_d_ff.valid <= in_stage.tag.valid;
         strobe_ff      <= tag_d_ff.valid;
      end

      tag_d_ff.last       <= in_stage.tag.last;
      tag_d_ff.sample     <= in_stage.tag.sample;
      scaled_d_ff         <= SCALE_BITS'(alpha) * SCALE_BITS'(in_stage.q);
      word_ff.activation  <= activation_in;
      word_ff.last_out    <= tag_d_ff.last;
   end

   assign out_strobe = strobe_ff;
   assign out_word   = word_ff;

endmodule

`default_nettype wire

>>> design/elu_activation.sv
// Top level of the ELU activation block: alpha register and the six-stage pipeline.
`default_nettype none

// ELU activation, one signed Q3.12 word in and one word out per clock cycle.
// busy is always low, so a word is taken at every edge where start is high.
// Each result appears on rsp_word with rsp_strobe high for one cycle, in the
// order the words came in; the receiver cannot stall it, and the fixed
// six-stage pipeline (index, table read, interpolation multiply, subtract,
// alpha multiply, round and saturate) sets the one-word-per-cycle rate.
// Non-negative samples pass through unchanged and last is carried
// alongside.
// The alpha register is written through the csr channel, which is always
// ready, and should be changed only while no words are in flight.
module elu_activation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire elu_pkg::req_word_type          req_word,
   output logic                                rsp_strobe,
   output elu_pkg::rsp_word_type               rsp_word,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [elu_pkg::ALPHA_BITS-1:0] csr_data
);
   import elu_pkg::*;

   logic [ALPHA_BITS-1:0] alpha_gain_ff;
   logic [ALPHA_BITS-1:0] alpha_gain_in;
   index_stage_type       index_stage;
   q_stage_type           q_stage;

   // The pipeline never holds off input, and the register is always writable.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Alpha register.
   always_comb begin
      alpha_gain_in = alpha_gain_ff;
      if (csr_valid && csr_ready) begin
         alpha_gain_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_gain_ff <= ALPHA_RESET;
      end else begin
         alpha_gain_ff <= alpha_gain_in;
      end
   end

   // Pipeline.
   elu_index u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_word   (req_word),
      .out_stage (index_stage)
   );

   elu_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (index_stage),
      .out_stage (q_stage)
   );

   elu_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (q_stage),
      .alpha      (alpha_gain_ff),
      .out_strobe (rsp_strobe),
      .out_word   (rsp_word)
   );

endmodule

`default_nettype wire

>>> test/tb_elu_activation.sv
// Self-checking testbench for the ELU activation block: directed, alpha-sweep and random words.
`default_nettype none

module tb_elu_activation;
   import elu_pkg::*;

   localparam int SEG_SHIFT   = FRAC_BITS + 3;
   localparam int DRAIN_WAIT  = 12;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_WORDS = 234;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_strobe;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ALPHA_BITS-1:0] csr_data = '0;

   // Model state: the alpha register and the exp(-8k/N) table in Q32.
   logic [ALPHA_BITS-1:0] alpha_model;
   logic [63:0] exp_table [0:TABLE_ENTRIES];

   rsp_word_type pending_activations [$];
   int mismatch_count = 0;
   int burst_left = 0;
   int stall_cycles = 0;

   elu_activation dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fills the table from a truncated alternating series for exp(-8/N).
   task automatic fill_exp_table();
      logic [63:0] term;
      logic signed [63:0] series;
      logic [63:0] step_ratio;
      term   = 64'd1 << 32;
      series = $signed(term);
      for (int n = 1; n <= 24; n++) begin
         term = (term * 64'd8) / (64'(TABLE_ENTRIES) * 64'(n));
         if (n % 2 == 1) begin
            series = series - $signed(term);
         end else begin
            series = series + $signed(term);
         end
      end
      step_ratio   = $unsigned(series);
      exp_table[0] = 64'd1 << 32;
      for (int k = 1; k <= TABLE_ENTRIES; k++) begin
         exp_table[k] = (exp_table[k-1] * step_ratio) >> 32;
      end
   endtask

   // Expected ELU output for one word under the current alpha.
   function automatic rsp_word_type elu_expected(req_word_type w);
      rsp_word_type r;
      logic [15:0] raw;
      logic [63:0] mag, pos, seg, frac, e_val, drop, q_val, rounded;
      longint value;
      raw = w.sample;
      if (raw[15]) begin
         mag  = 64'h10000 - {48'd0, raw};
         pos  = mag * 64'(TABLE_ENTRIES);
         seg  = pos >> SEG_SHIFT;
         frac = pos & ((64'd1 << SEG_SHIFT) - 64'd1);
         if (seg >= 64'(TABLE_ENTRIES)) begin
            e_val = exp_table[TABLE_ENTRIES];
         end else begin
            drop  = exp_table[seg] - exp_table[seg+1];
            e_val = exp_table[seg] - ((drop * frac) >> SEG_SHIFT);
         end
         q_val   = (64'd1 << 32) - e_val;
         rounded = ({49'd0, alpha_model} * q_val + (64'd1 << 31)) >> 32;
         value   = -longint'(rounded);
      end else begin
         value = longint'({48'd0, raw});
      end
      // Saturation guard on the output format.
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      r.activation = 16'(value);
      r.last_out   = w.last;
      return r;
   endfunction

   // Compares each result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_strobe) begin
         if (pending_activations.size() == 0) begin
            $error("unexpected result word: activation %0d last_out %0b",
                   rsp_word.activation, rsp_word.last_out);
            mismatch_count++;
         end else begin
            exp_word = pending_activations.pop_front();
            if (rsp_word.activation !== exp_word.activation) begin
               $error("activation: expected %0d, actual %0d",
                      exp_word.activation, rsp_word.activation);
               mismatch_count++;
            end
            if (rsp_word.last_out !== exp_word.last_out) begin
               $error("last_out: expected %0b, actual %0b",
                      exp_word.last_out, rsp_word.last_out);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_elu_activation NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Sends one word, with random gaps between bursts; start stays high afterward.
   task automatic send_sample(input logic [15:0] sample, input logic last);
      req_word_type w;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      w.sample = sample;
      w.last   = last;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_activations.insert(pending_activations.size(), elu_expected(w));
   endtask

   // Holds the sender off until every expected result has come back.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_activations.size() != 0);
   endtask

   task automatic write_alpha(input logic [ALPHA_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      alpha_model = value;
   endtask

   // Mix of full-range values, table segment boundaries and the far negative end.
   function automatic logic [15:0] random_sample();
      int m;
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: begin
            m = $urandom_range(1, 4096);
            return 16'(-m);
         end
         2: return 16'(-32768 + int'($urandom_range(0, 600)));
         3: begin
            m = 512 * $urandom_range(1, 63) + $urandom_range(0, 2) - 1;
            return 16'(-m);
         end
         4: return 16'($urandom_range(0, 32767));
         default: begin
            m = $urandom_range(1, 32768);
            return 16'(-m);
         end
      endcase
   endfunction

   // Field extremes and segment edges under the reset alpha of 1.0.
   task automatic test_reset_alpha();
      send_sample(16'h0000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h0001, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8001, 1'b1);
      send_sample(16'hF000, 1'b0);
      send_sample(16'hF001, 1'b0);
      send_sample(16'hFE00, 1'b0);
      send_sample(16'hFDFF, 1'b0);
      send_sample(16'hFE01, 1'b1);
      send_sample(16'h4000, 1'b0);
      send_sample(16'hC000, 1'b0);
      send_sample(16'h8200, 1'b1);
      wait_idle();
   endtask

   // Zero alpha must flatten every negative sample; full-scale alpha is the other end.
   task automatic test_alpha_extremes();
      write_alpha('0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h1234, 1'b1);
      write_alpha('1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'hF000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      wait_idle();
   endtask

   // Random words over several alpha settings.
   task automatic test_random_phases();
      logic [ALPHA_BITS-1:0] alphas [6];
      alphas[0] = ALPHA_RESET;
      alphas[1] = '1;
      alphas[2] = ALPHA_BITS'($urandom_range(1, 32766));
      alphas[3] = '0;
      alphas[4] = ALPHA_BITS'(1);
      alphas[5] = ALPHA_BITS'($urandom_range(8192, 32767));
      foreach (alphas[i]) begin
         write_alpha(alphas[i]);
         repeat (PHASE_WORDS) begin
            send_sample(random_sample(), ($urandom_range(0, 15) == 0));
         end
      end
      wait_idle();
   endtask

   // The sender stops between bursts until the pipeline has emptied.
   task automatic test_drain_pause();
      write_alpha(ALPHA_BITS'($urandom_range(1, 32767)));
      repeat (3) begin
         repeat (20) send_sample(random_sample(), ($urandom_range(0, 7) == 0));
         wait_idle();
      end
   endtask

   initial begin
      fill_exp_table();
      alpha_model = ALPHA_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_alpha();
      test_alpha_extremes();
      test_random_phases();
      test_drain_pause();
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_activations.size() == 0) begin
         $display("tb_elu_activation OK");
      end else begin
         $display("tb_elu_activation NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
